// File: src/aar_pkg.sv
// Package for the axis-angle rotation matrix block: field widths, fixed-point
// constants, transaction structures, pipeline side-band structures and the
// CORDIC arctangent table. Depends on nothing.
package aar_pkg;

	// Field widths
	localparam int ANGLE_W = 18;
	localparam int AXIS_W  = 16;
	localparam int RES_W   = 16;

	// Internal widths
	localparam int XY_W    = 33;   // CORDIC x, y, z and the cosine and sine in Q30
	localparam int SUM_W   = 32;   // sum of the squared axis components
	localparam int SQ_W    = 62;   // normalised radicand, in [2^60, 2^62)
	localparam int Q_W     = 31;   // integer square root, in [2^30, 2^31)
	localparam int NUM_W   = 76;   // scaled axis magnitude for the division
	localparam int E_W     = 5;    // normalisation exponent
	localparam int U_W     = 32;   // signed unit component in Q30

	// Angle handling, in units of 1/128 degree
	localparam int TURN    = 46080;
	localparam int HALF    = 23040;
	localparam int QUARTER = 11520;
	localparam logic signed [XY_W-1:0] RAD_PER_UNIT = 33'sd146409;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN  = 33'sd652032874;

	// Chain lengths
	localparam int CORDIC_STEPS = 30;
	localparam int NORM_STEPS   = 4;
	localparam int SQRT_STEPS   = 31;
	localparam int DIV_STEPS    = 31;
	localparam int LANES        = 3;

	// Request and result transactions
	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_deg;
		logic signed [AXIS_W-1:0]  axis_x;
		logic signed [AXIS_W-1:0]  axis_y;
		logic signed [AXIS_W-1:0]  axis_z;
	} req_t;

	typedef struct packed {
		logic signed [RES_W-1:0] r00;
		logic signed [RES_W-1:0] r01;
		logic signed [RES_W-1:0] r02;
		logic signed [RES_W-1:0] r10;
		logic signed [RES_W-1:0] r11;
		logic signed [RES_W-1:0] r12;
		logic signed [RES_W-1:0] r20;
		logic signed [RES_W-1:0] r21;
		logic signed [RES_W-1:0] r22;
		logic                    axis_zero;
	} res_t;

	// Side band carried along the CORDIC chain
	typedef struct packed {
		logic                          flip;
		logic                          zero;
		logic [SUM_W-1:0]              sum;
		logic [LANES-1:0][AXIS_W-1:0]  mag;
		logic [LANES-1:0]              sgn;
	} cor_side_t;

	// Side band carried through normalisation and the square root chain
	typedef struct packed {
		logic signed [XY_W-1:0]        c;
		logic signed [XY_W-1:0]        s;
		logic                          zero;
		logic [LANES-1:0][AXIS_W-1:0]  mag;
		logic [LANES-1:0]              sgn;
		logic [E_W-1:0]                e;
	} sq_side_t;

	// Side band carried through the divider chain
	typedef struct packed {
		logic signed [XY_W-1:0] c;
		logic signed [XY_W-1:0] s;
		logic                   zero;
		logic [LANES-1:0]       sgn;
	} dv_side_t;

	// Arctangent of 2^-i in Q30
	function automatic logic signed [XY_W-1:0] atan_q30(input int i);
		logic signed [XY_W-1:0] a;
		case (i)
			0:  a = 33'sd843314857;
			1:  a = 33'sd497837830;
			2:  a = 33'sd263043837;
			3:  a = 33'sd133525159;
			4:  a = 33'sd67021687;
			5:  a = 33'sd33543516;
			6:  a = 33'sd16775851;
			7:  a = 33'sd8388437;
			8:  a = 33'sd4194283;
			9:  a = 33'sd2097149;
			default: begin
				if (i >= 10 && i < 31) begin
					a = 33'sd1 <<< (30 - i);
				end else begin
					a = '0;
				end
			end
		endcase
		return a;
	endfunction

endpackage

// File: src/aar_stream_if.sv
// Valid/ready stream interface used for the request and result channels.
// Depends on nothing; the payload type is given per instance.
interface aar_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/aar_cordic_cell.sv
// One rotation step of the CORDIC chain, with a pass-through side band.
// Depends on aar_pkg.
module aar_cordic_cell #(
	parameter int STEP   = 0,
	parameter int SIDE_W = 1
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [aar_pkg::XY_W-1:0]        x_in,
	input  logic signed [aar_pkg::XY_W-1:0]        y_in,
	input  logic signed [aar_pkg::XY_W-1:0]        z_in,
	input  logic [SIDE_W-1:0]                      side_in,
	output logic signed [aar_pkg::XY_W-1:0]        x_q,
	output logic signed [aar_pkg::XY_W-1:0]        y_q,
	output logic signed [aar_pkg::XY_W-1:0]        z_q,
	output logic [SIDE_W-1:0]                      side_q
);

	localparam logic signed [aar_pkg::XY_W-1:0] ATAN = aar_pkg::atan_q30(STEP);

	logic signed [aar_pkg::XY_W-1:0] dx;
	logic signed [aar_pkg::XY_W-1:0] dy;

	// Floor shifts of the cross terms
	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	// Rotate towards a zero residual angle; a non-negative residual turns positive.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[aar_pkg::XY_W-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + ATAN;
			end
			side_q <= side_in;
		end
	end

endmodule

// File: src/aar_sqrt_cell.sv
// One result bit of the restoring integer square root, with a side band.
// Depends on aar_pkg.
module aar_sqrt_cell #(
	parameter int STEP   = 0,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [aar_pkg::SQ_W-1:0]      rem_in,
	input  logic [aar_pkg::SQ_W-1:0]      root_in,
	input  logic [SIDE_W-1:0]             side_in,
	output logic [aar_pkg::SQ_W-1:0]      rem_q,
	output logic [aar_pkg::SQ_W-1:0]      root_q,
	output logic [SIDE_W-1:0]             side_q
);

	localparam int W = aar_pkg::SQ_W;
	localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

	logic [W-1:0] trial;

	assign trial = root_in + BIT;

	// Take the trial subtrahend when it fits and set this root bit.
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= (root_in >> 1) + BIT;
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in >> 1;
			end
			side_q <= side_in;
		end
	end

endmodule

// File: src/aar_div_cell.sv
// One quotient bit of three parallel restoring divisions sharing a divisor,
// with a side band. Depends on aar_pkg.
module aar_div_cell #(
	parameter int STEP   = 0,
	parameter int SIDE_W = 1
) (
	input  logic                                                  clk,
	input  logic                                                  en,
	input  logic [aar_pkg::Q_W-1:0]                               den_in,
	input  logic [aar_pkg::LANES-1:0][aar_pkg::NUM_W-1:0]         rem_in,
	input  logic [aar_pkg::LANES-1:0][aar_pkg::Q_W-1:0]           quot_in,
	input  logic [SIDE_W-1:0]                                     side_in,
	output logic [aar_pkg::Q_W-1:0]                               den_q,
	output logic [aar_pkg::LANES-1:0][aar_pkg::NUM_W-1:0]         rem_q,
	output logic [aar_pkg::LANES-1:0][aar_pkg::Q_W-1:0]           quot_q,
	output logic [SIDE_W-1:0]                                     side_q
);

	localparam int NW = aar_pkg::NUM_W;
	localparam int K  = aar_pkg::Q_W - 1 - STEP;

	logic [NW-1:0] dsh;

	// Divisor aligned to this quotient bit
	assign dsh = NW'(den_in) << K;

	// Each lane subtracts the aligned divisor when it fits.
	for (genvar l = 0; l < aar_pkg::LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in[l] >= dsh) begin
					rem_q[l]  <= rem_in[l] - dsh;
					quot_q[l] <= {quot_in[l][aar_pkg::Q_W-2:0], 1'b1};
				end else begin
					rem_q[l]  <= rem_in[l];
					quot_q[l] <= {quot_in[l][aar_pkg::Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q  <= den_in;
			side_q <= side_in;
		end
	end

endmodule

// File: src/axis_angle_rotation_matrix.sv
// Top level of the axis-angle rotation matrix block: angle reduction, CORDIC,
// axis normalisation, square root, division and the matrix entries.
// Depends on aar_pkg, aar_stream_if and the three cell modules.
//
// Usage: each request transaction carries an angle in 1/128 degree and an
// axis of any length; each yields exactly one result transaction with the
// nine entries of the Rodrigues rotation matrix, rounded and saturated to
// plus or minus one, and a flag for an all-zero axis (entries then zero).
// The datapath is one pipeline of 101 register stages: two for angle
// reduction and squaring, 30 CORDIC cells, four normalisation stages,
// 31 square-root cells, 31 divider cells and three product and rounding
// stages, the last of which is the output register.
// Throughput is one transaction per cycle while the pipeline is not stalled; every cell is a single step.
// While the result is held valid and not taken, the whole pipeline freezes
// and request.ready is low; as soon as the result is taken, or the output
// register is empty, the pipeline advances and requests are taken again.
// Reset clears the valid line only, so no result appears until requests do.
module axis_angle_rotation_matrix #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	aar_stream_if.sink   request,
	aar_stream_if.source result
);

	localparam int XW  = aar_pkg::XY_W;
	localparam int CS  = aar_pkg::CORDIC_STEPS;
	localparam int NS  = aar_pkg::NORM_STEPS;
	localparam int SS  = aar_pkg::SQRT_STEPS;
	localparam int DS  = aar_pkg::DIV_STEPS;
	localparam int L   = aar_pkg::LANES;
	localparam int AW  = aar_pkg::AXIS_W;
	localparam int SW  = aar_pkg::SQ_W;
	localparam int NW  = aar_pkg::NUM_W;
	localparam int QW  = aar_pkg::Q_W;
	localparam int UW  = aar_pkg::U_W;
	localparam int EW  = aar_pkg::E_W;
	localparam int RW  = aar_pkg::RES_W;
	localparam int ACC_W = 70;
	localparam int PP_W  = 2 * UW;
	localparam int PS_W  = PP_W - 30;
	localparam int PT_W  = PS_W + XW;
	localparam int US_W  = UW + XW;

	localparam int COR_W = $bits(aar_pkg::cor_side_t);
	localparam int SQS_W = $bits(aar_pkg::sq_side_t);
	localparam int DVS_W = $bits(aar_pkg::dv_side_t);

	// Positions in the valid line
	localparam int N_STAGES = 2 + CS + NS + SS + DS + 3;
	localparam int SQ_END   = 2 + CS + NS + SS - 1;
	localparam int DV_END   = SQ_END + DS;

	// Rounding and saturation of the entries
	localparam int RSH = 60 - OUT_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (RSH - 1);
	localparam logic signed [ACC_W-1:0] LIM = ACC_W'(1) <<< OUT_FRAC_BITS;

	function automatic logic [RW-1:0] finish_entry(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] v;
		v = (acc + HALF_LSB) >>> RSH;
		if (v > LIM) begin
			v = LIM;
		end else if (v < -LIM) begin
			v = -LIM;
		end
		return v[RW-1:0];
	endfunction

	// Pipeline control: advance unless a result waits to be taken.
	logic                en;
	logic [N_STAGES-1:0] vld_q;

	assign en            = !vld_q[N_STAGES-1] || result.ready;
	assign request.ready = en;
	assign result.valid  = vld_q[N_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N_STAGES-2:0], request.valid};
		end
	end

	// Stage 1: angle modulo one turn, axis magnitudes, signs and squares.
	logic signed [19:0]       ang_ext;
	logic [15:0]              ang_mod;
	logic [L-1:0][AW-1:0]     mag_in;
	logic [L-1:0]             sgn_in;
	logic [15:0]              ang_mod_s1;
	logic [L-1:0][AW-1:0]     mag_s1;
	logic [L-1:0]             sgn_s1;
	logic [L-1:0][31:0]       sq_s1;
	logic                     zero_s1;

	assign ang_ext   = 20'(request.data.angle_deg) + 20'sd138240;
	assign sgn_in[0] = request.data.axis_x[AW-1];
	assign sgn_in[1] = request.data.axis_y[AW-1];
	assign sgn_in[2] = request.data.axis_z[AW-1];
	assign mag_in[0] = sgn_in[0] ? AW'(-request.data.axis_x) : AW'(request.data.axis_x);
	assign mag_in[1] = sgn_in[1] ? AW'(-request.data.axis_y) : AW'(request.data.axis_y);
	assign mag_in[2] = sgn_in[2] ? AW'(-request.data.axis_z) : AW'(request.data.axis_z);

	always_comb begin
		if (ang_ext >= 20'(5 * aar_pkg::TURN)) begin
			ang_mod = 16'(ang_ext - 20'(5 * aar_pkg::TURN));
		end else if (ang_ext >= 20'(4 * aar_pkg::TURN)) begin
			ang_mod = 16'(ang_ext - 20'(4 * aar_pkg::TURN));
		end else if (ang_ext >= 20'(3 * aar_pkg::TURN)) begin
			ang_mod = 16'(ang_ext - 20'(3 * aar_pkg::TURN));
		end else if (ang_ext >= 20'(2 * aar_pkg::TURN)) begin
			ang_mod = 16'(ang_ext - 20'(2 * aar_pkg::TURN));
		end else if (ang_ext >= 20'(aar_pkg::TURN)) begin
			ang_mod = 16'(ang_ext - 20'(aar_pkg::TURN));
		end else begin
			ang_mod = 16'(ang_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_mod_s1 <= ang_mod;
			mag_s1     <= mag_in;
			sgn_s1     <= sgn_in;
			for (int l = 0; l < L; l++) begin
				sq_s1[l] <= 32'(mag_in[l]) * 32'(mag_in[l]);
			end
			zero_s1    <= (request.data.axis_x == '0) && (request.data.axis_y == '0) &&
				(request.data.axis_z == '0);
		end
	end

	// Stage 2: fold the angle into one quarter turn either side, scale to radians.
	logic signed [16:0]        ang_half;
	logic signed [16:0]        ang_fold;
	logic                      flip;
	logic signed [XW-1:0]      z0_s2;
	aar_pkg::cor_side_t        side_s2;

	always_comb begin
		if (ang_mod_s1 >= 16'(aar_pkg::HALF)) begin
			ang_half = 17'(ang_mod_s1) - 17'sd46080;
		end else begin
			ang_half = 17'(ang_mod_s1);
		end
		flip     = 1'b0;
		ang_fold = ang_half;
		if (ang_half > 17'sd11520) begin
			ang_fold = ang_half - 17'(aar_pkg::HALF);
			flip     = 1'b1;
		end else if (ang_half < -17'sd11520) begin
			ang_fold = ang_half + 17'(aar_pkg::HALF);
			flip     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z0_s2        <= XW'(ang_fold) * aar_pkg::RAD_PER_UNIT;
			side_s2.flip <= flip;
			side_s2.zero <= zero_s1;
			side_s2.sum  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			side_s2.mag  <= mag_s1;
			side_s2.sgn  <= sgn_s1;
		end
	end

	// CORDIC chain
	logic signed [XW-1:0] cx [0:CS];
	logic signed [XW-1:0] cy [0:CS];
	logic signed [XW-1:0] cz [0:CS];
	logic [COR_W-1:0]     cside [0:CS];

	assign cx[0]    = aar_pkg::CORDIC_GAIN;
	assign cy[0]    = '0;
	assign cz[0]    = z0_s2;
	assign cside[0] = side_s2;

	for (genvar k = 0; k < CS; k++) begin : g_cordic
		aar_cordic_cell #(.STEP(k), .SIDE_W(COR_W)) u_cell (
			.clk     (clk),
			.en      (en),
			.x_in    (cx[k]),
			.y_in    (cy[k]),
			.z_in    (cz[k]),
			.side_in (cside[k]),
			.x_q     (cx[k+1]),
			.y_q     (cy[k+1]),
			.z_q     (cz[k+1]),
			.side_q  (cside[k+1])
		);
	end

	// Normalisation: shift the sum of squares by an even amount into [2^60, 2^62).
	aar_pkg::cor_side_t cor_end;
	logic [SW-1:0]      nv [0:NS];
	aar_pkg::sq_side_t  nside [0:NS];

	assign cor_end = cside[CS];

	always_comb begin
		nv[0]         = {cor_end.sum, 30'b0};
		nside[0].c    = cor_end.flip ? -cx[CS] : cx[CS];
		nside[0].s    = cor_end.flip ? -cy[CS] : cy[CS];
		nside[0].zero = cor_end.zero;
		nside[0].mag  = cor_end.mag;
		nside[0].sgn  = cor_end.sgn;
		nside[0].e    = EW'(15);
	end

	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int SH = 16 >> k;
		aar_pkg::sq_side_t side_d;

		// The exponent grows by half the shift when the top bits are clear.
		always_comb begin
			side_d = nside[k];
			if (nv[k][SW-1 -: SH] == '0) begin
				side_d.e = nside[k].e + EW'(SH / 2);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nside[k+1] <= side_d;
				if (nv[k][SW-1 -: SH] == '0) begin
					nv[k+1] <= nv[k] << SH;
				end else begin
					nv[k+1] <= nv[k];
				end
			end
		end
	end

	// Square root chain
	logic [SW-1:0]    srem [0:SS];
	logic [SW-1:0]    sroot [0:SS];
	logic [SQS_W-1:0] sside [0:SS];

	assign srem[0]  = nv[NS];
	assign sroot[0] = '0;
	assign sside[0] = nside[NS];

	for (genvar k = 0; k < SS; k++) begin : g_sqrt
		aar_sqrt_cell #(.STEP(k), .SIDE_W(SQS_W)) u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (srem[k]),
			.root_in (sroot[k]),
			.side_in (sside[k]),
			.rem_q   (srem[k+1]),
			.root_q  (sroot[k+1]),
			.side_q  (sside[k+1])
		);
	end

	// Divider chain: unit component magnitude = |v| * 2^(e+30) / root.
	aar_pkg::sq_side_t              sq_end;
	aar_pkg::dv_side_t              dv_start;
	logic [QW-1:0]                  dden [0:DS];
	logic [L-1:0][NW-1:0]           drem [0:DS];
	logic [L-1:0][QW-1:0]           dquot [0:DS];
	logic [DVS_W-1:0]               dside [0:DS];

	assign sq_end = sside[SS];

	always_comb begin
		dv_start.c    = sq_end.c;
		dv_start.s    = sq_end.s;
		dv_start.zero = sq_end.zero;
		dv_start.sgn  = sq_end.sgn;
		for (int l = 0; l < L; l++) begin
			drem[0][l] = NW'(sq_end.mag[l]) << ({1'b0, sq_end.e} + 6'd30);
		end
	end

	assign dden[0]  = sroot[SS][QW-1:0];
	assign dquot[0] = '0;
	assign dside[0] = dv_start;

	for (genvar k = 0; k < DS; k++) begin : g_div
		aar_div_cell #(.STEP(k), .SIDE_W(DVS_W)) u_cell (
			.clk     (clk),
			.en      (en),
			.den_in  (dden[k]),
			.rem_in  (drem[k]),
			.quot_in (dquot[k]),
			.side_in (dside[k]),
			.den_q   (dden[k+1]),
			.rem_q   (drem[k+1]),
			.quot_q  (dquot[k+1]),
			.side_q  (dside[k+1])
		);
	end

	// Product stage 1: pair products and unit component times sine.
	aar_pkg::dv_side_t        dv_end;
	logic signed [UW-1:0]     u [0:L-1];
	logic signed [PP_W-1:0]   pp_xx_s1, pp_xy_s1, pp_xz_s1, pp_yy_s1, pp_yz_s1, pp_zz_s1;
	logic signed [US_W-1:0]   us_x_s1, us_y_s1, us_z_s1;
	logic signed [XW-1:0]     c_p1, t_p1;
	logic                     zero_p1;

	assign dv_end = dside[DS];

	always_comb begin
		for (int l = 0; l < L; l++) begin
			u[l] = dv_end.sgn[l] ? -UW'(dquot[DS][l]) : UW'(dquot[DS][l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_xx_s1 <= u[0] * u[0];
			pp_xy_s1 <= u[0] * u[1];
			pp_xz_s1 <= u[0] * u[2];
			pp_yy_s1 <= u[1] * u[1];
			pp_yz_s1 <= u[1] * u[2];
			pp_zz_s1 <= u[2] * u[2];
			us_x_s1  <= u[0] * dv_end.s;
			us_y_s1  <= u[1] * dv_end.s;
			us_z_s1  <= u[2] * dv_end.s;
			c_p1     <= dv_end.c;
			t_p1     <= (XW'(1) <<< 30) - dv_end.c;
			zero_p1  <= dv_end.zero;
		end
	end

	// Product stage 2: floor-shifted pair products times (1 - cos).
	logic signed [PT_W-1:0]  pt_xx_s2, pt_xy_s2, pt_xz_s2, pt_yy_s2, pt_yz_s2, pt_zz_s2;
	logic signed [US_W-1:0]  us_x_s2, us_y_s2, us_z_s2;
	logic signed [XW-1:0]    c_p2;
	logic                    zero_p2;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_xx_s2 <= PS_W'(pp_xx_s1 >>> 30) * t_p1;
			pt_xy_s2 <= PS_W'(pp_xy_s1 >>> 30) * t_p1;
			pt_xz_s2 <= PS_W'(pp_xz_s1 >>> 30) * t_p1;
			pt_yy_s2 <= PS_W'(pp_yy_s1 >>> 30) * t_p1;
			pt_yz_s2 <= PS_W'(pp_yz_s1 >>> 30) * t_p1;
			pt_zz_s2 <= PS_W'(pp_zz_s1 >>> 30) * t_p1;
			us_x_s2  <= us_x_s1;
			us_y_s2  <= us_y_s1;
			us_z_s2  <= us_z_s1;
			c_p2     <= c_p1;
			zero_p2  <= zero_p1;
		end
	end

	// Output stage: add the cosine or cross terms, round and saturate.
	logic signed [ACC_W-1:0] cq;
	logic signed [ACC_W-1:0] ux_s, uy_s, uz_s;
	aar_pkg::res_t           res_d;
	aar_pkg::res_t           res_q;

	assign cq   = ACC_W'(c_p2) <<< 30;
	assign ux_s = ACC_W'(us_x_s2);
	assign uy_s = ACC_W'(us_y_s2);
	assign uz_s = ACC_W'(us_z_s2);

	always_comb begin
		if (zero_p2) begin
			res_d           = '0;
			res_d.axis_zero = 1'b1;
		end else begin
			res_d.r00       = finish_entry(ACC_W'(pt_xx_s2) + cq);
			res_d.r01       = finish_entry(ACC_W'(pt_xy_s2) - uz_s);
			res_d.r02       = finish_entry(ACC_W'(pt_xz_s2) + uy_s);
			res_d.r10       = finish_entry(ACC_W'(pt_xy_s2) + uz_s);
			res_d.r11       = finish_entry(ACC_W'(pt_yy_s2) + cq);
			res_d.r12       = finish_entry(ACC_W'(pt_yz_s2) - ux_s);
			res_d.r20       = finish_entry(ACC_W'(pt_xz_s2) - uy_s);
			res_d.r21       = finish_entry(ACC_W'(pt_yz_s2) + ux_s);
			res_d.r22       = finish_entry(ACC_W'(pt_zz_s2) + cq);
			res_d.axis_zero = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign result.data = res_q;

	// A zero axis gives zeros on the diagonal and in r01, r12 and r20.
	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.axis_zero) |->
		(result.data.r00 == '0 && result.data.r11 == '0 && result.data.r22 == '0 &&
		 result.data.r01 == '0 && result.data.r12 == '0 && result.data.r20 == '0))
		else $error("zero axis with non-zero matrix entries");

	// The square root of a normalised radicand has its top bit set.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[SQ_END] && !sq_end.zero) |-> sroot[SS][QW-1])
		else $error("square root outside [2^30, 2^31)");

	// Each division leaves a remainder below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DV_END] && !dv_end.zero) |->
		(drem[DS][0] < NW'(dden[DS]) && drem[DS][1] < NW'(dden[DS]) &&
		 drem[DS][2] < NW'(dden[DS])))
		else $error("division remainder not below divisor");

	// A stalled pipeline holds its whole valid line.
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(!en) |=> $stable(vld_q))
		else $error("valid line moved while stalled");

endmodule
